[hdl/bmns_pkg.sv]
`timescale 1ns / 1ps
package bmns_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int LOG_BITS      = 28;
   localparam int SQRT_STAGES   = 16;
   localparam int RAD_DEPTH     = 1 + LOG_BITS + 1 + SQRT_STAGES;
   localparam int TRIG_LEVELS   = 5;
   localparam int ANG_DEPTH     = 3 + 3 * TRIG_LEVELS + 1;
   localparam int ALIGN_DEPTH   = RAD_DEPTH - ANG_DEPTH;

   localparam logic [30:0] ONE_Q30     = 31'h4000_0000;
   localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
   localparam logic [30:0] TWO_LN2_Q30 = 31'd1488522236;

   localparam logic [6:0] SIN_DIV [0:3] = '{7'd72, 7'd42, 7'd20, 7'd6};
   localparam logic [6:0] COS_DIV [0:4] = '{7'd90, 7'd56, 7'd30, 7'd12, 7'd2};
   localparam logic [31:0] SIN_RECIP [0:3] =
      '{32'd59652323, 32'd102261126, 32'd214748364, 32'd715827882};
   localparam logic [31:0] COS_RECIP [0:4] =
      '{32'd47721858, 32'd76695844, 32'd143165576, 32'd357913941, 32'd2147483648};

   typedef enum logic [1:0] {
      CSR_MEAN  = 2'd0,
      CSR_STD   = 2'd1,
      CSR_FLOOR = 2'd2,
      CSR_CLIP  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [31:0] uniform_radius;
      logic [31:0] uniform_angle;
   } req_type;

   typedef struct packed {
      logic signed [31:0] first_value;
      logic signed [31:0] second_value;
   } rsp_type;

   typedef struct packed {
      logic [30:0] cos_mag;
      logic        cos_neg;
      logic [30:0] sin_mag;
      logic        sin_neg;
   } trig_type;

   // correct a reciprocal quotient that may be one short
   function automatic logic [29:0] div_fix(logic [29:0] n, logic [29:0] q0, logic [6:0] k);
      logic [37:0] r;
      r = 38'(n) - 38'(q0) * 38'(k);
      return (r >= 38'(k)) ? q0 + 30'd1 : q0;
   endfunction

endpackage

[hdl/box_muller_normal_scaler.sv]
`timescale 1ns / 1ps
// Box-Muller Gaussian pair source. Each accepted word of two 32-bit uniforms gives one
// word of two normal samples, scaled by std_dev, offset by mean_value, saturated and
// optionally floored, all in signed Q16.16. The datapath is one pipeline of 49 register
// stages: the radius path (leading-one normalise, 28 squaring stages for the base-2
// logarithm, one scaling multiply, 16 square-root stages of two digits each) and three
// output stages (product, scaling, saturation) set that depth, while the sine/cosine
// path runs alongside and is delayed to meet it. One word is taken every cycle while no
// result is held at the output, and a held result freezes the whole pipeline without
// loss.
module box_muller_normal_scaler import bmns_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_write,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_data
);

   localparam int DEPTH = RAD_DEPTH + 3;

   logic signed [31:0] mean_ff, floor_ff;
   logic [30:0]        std_ff;
   logic               clip_ff;

   logic               vld_ff [0:DEPTH-1];
   logic               adv;
   logic [31:0]        root;
   trig_type           trig;
   trig_type           dl_ff [0:ALIGN_DEPTH-1];

   logic [31:0]        zc_ff, zs_ff;
   logic               nc1_ff, ns1_ff, nc2_ff, ns2_ff;
   logic [34:0]        vc_ff, vs_ff;
   rsp_type            rsp_ff;

   logic [62:0]        mc, ms;
   logic [63:0]        pc, ps;

   function automatic logic signed [31:0] finish(logic [34:0] v, logic neg,
                                                 logic signed [31:0] mean,
                                                 logic signed [31:0] floor_v,
                                                 logic clip);
      logic signed [36:0] s;
      logic signed [31:0] o;
      s = neg ? -$signed({2'b00, v}) : $signed({2'b00, v});
      s = s + 37'(mean);
      if (s > 37'sd2147483647) begin
         o = 32'sh7FFF_FFFF;
      end else if (s < -37'sd2147483648) begin
         o = 32'sh8000_0000;
      end else begin
         o = s[31:0];
      end
      if (clip && (o < floor_v)) begin
         o = floor_v;
      end
      return o;
   endfunction

   always_ff @(posedge clock) begin
      if (reset) begin
         mean_ff  <= '0;
         std_ff   <= 31'(64'd1 << FRAC_BITS);
         floor_ff <= 32'sh8000_0000;
         clip_ff  <= 1'b0;
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_MEAN:  mean_ff  <= csr_data;
            CSR_STD:   std_ff   <= csr_data[30:0];
            CSR_FLOOR: floor_ff <= csr_data;
            CSR_CLIP:  clip_ff  <= csr_data[0];
            default:   ;
         endcase
      end
   end

   assign adv       = !vld_ff[DEPTH-1] || rsp_ready;
   assign req_ready = adv;
   assign rsp_valid = vld_ff[DEPTH-1];
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (adv) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < DEPTH; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   bmns_radius u_radius (
      .clock          (clock),
      .adv            (adv),
      .uniform_radius (req_data.uniform_radius),
      .root           (root)
   );

   bmns_trig u_trig (
      .clock         (clock),
      .adv           (adv),
      .uniform_angle (req_data.uniform_angle),
      .trig          (trig)
   );

   always_ff @(posedge clock) begin
      if (adv) begin
         dl_ff[0] <= trig;
         for (int i = 1; i < ALIGN_DEPTH; i++) begin
            dl_ff[i] <= dl_ff[i-1];
         end
      end
   end

   assign mc = 63'(root) * 63'(dl_ff[ALIGN_DEPTH-1].cos_mag);
   assign ms = 63'(root) * 63'(dl_ff[ALIGN_DEPTH-1].sin_mag);
   assign pc = 64'(std_ff) * 64'(zc_ff) + 64'h1000_0000;
   assign ps = 64'(std_ff) * 64'(zs_ff) + 64'h1000_0000;

   always_ff @(posedge clock) begin
      if (adv) begin
         zc_ff  <= mc[61:30];
         zs_ff  <= ms[61:30];
         nc1_ff <= dl_ff[ALIGN_DEPTH-1].cos_neg;
         ns1_ff <= dl_ff[ALIGN_DEPTH-1].sin_neg;
         vc_ff  <= pc[63:29];
         vs_ff  <= ps[63:29];
         nc2_ff <= nc1_ff;
         ns2_ff <= ns1_ff;
         rsp_ff <= '{first_value:  finish(vc_ff, nc2_ff, mean_ff, floor_ff, clip_ff),
                     second_value: finish(vs_ff, ns2_ff, mean_ff, floor_ff, clip_ff)};
      end
   end

endmodule

[hdl/bmns_radius.sv]
`timescale 1ns / 1ps
module bmns_radius import bmns_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  logic [31:0] uniform_radius,
   output logic [31:0] root
);

   logic [31:0] lx_ff [0:LOG_BITS];
   logic [LOG_BITS-1:0] lf_ff [0:LOG_BITS];
   logic [5:0]  lk_ff [0:LOG_BITS];

   logic [35:0] rem_ff [0:SQRT_STAGES];
   logic [31:0] rt_ff  [0:SQRT_STAGES];
   logic [33:0] yv_ff  [0:SQRT_STAGES];

   logic [31:0] u;
   logic [4:0]  lead;
   logic [31:0] norm;
   logic [33:0] ell;
   logic [64:0] lp;

   always_comb begin
      u = (uniform_radius == 32'd0) ? 32'd1 : uniform_radius;
      lead = 5'd0;
      for (int i = 0; i < 32; i++) begin
         if (u[i]) begin
            lead = 5'(i);
         end
      end
      norm = u << (5'd31 - lead);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lx_ff[0] <= norm;
         lf_ff[0] <= '0;
         lk_ff[0] <= 6'd32 - 6'(lead);
      end
   end

   for (genvar g = 1; g <= LOG_BITS; g++) begin : g_log
      logic [63:0] sq;
      assign sq = 64'(lx_ff[g-1]) * 64'(lx_ff[g-1]);
      always_ff @(posedge clock) begin
         if (adv) begin
            lx_ff[g] <= sq[63] ? sq[63:32] : sq[62:31];
            lf_ff[g] <= {lf_ff[g-1][LOG_BITS-2:0], sq[63]};
            lk_ff[g] <= lk_ff[g-1];
         end
      end
   end

   assign ell = {lk_ff[LOG_BITS], {LOG_BITS{1'b0}}} - 34'(lf_ff[LOG_BITS]);
   assign lp  = 65'(ell) * 65'(TWO_LN2_Q30);

   always_ff @(posedge clock) begin
      if (adv) begin
         rem_ff[0] <= '0;
         rt_ff[0]  <= '0;
         yv_ff[0]  <= lp[63:30];
      end
   end

   for (genvar j = 1; j <= SQRT_STAGES; j++) begin : g_sqrt
      logic [63:0] v;
      logic [35:0] r1, t1, r2, t2, rem_a, rem_b;
      logic [31:0] rt_a, rt_b;
      always_comb begin
         v  = {yv_ff[j-1], 30'd0};
         r1 = {rem_ff[j-1][33:0], v[63-4*(j-1) -: 2]};
         t1 = {2'b00, rt_ff[j-1], 2'b01};
         if (r1 >= t1) begin
            rem_a = r1 - t1;
            rt_a  = {rt_ff[j-1][30:0], 1'b1};
         end else begin
            rem_a = r1;
            rt_a  = {rt_ff[j-1][30:0], 1'b0};
         end
         r2 = {rem_a[33:0], v[61-4*(j-1) -: 2]};
         t2 = {2'b00, rt_a, 2'b01};
         if (r2 >= t2) begin
            rem_b = r2 - t2;
            rt_b  = {rt_a[30:0], 1'b1};
         end else begin
            rem_b = r2;
            rt_b  = {rt_a[30:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (adv) begin
            rem_ff[j] <= rem_b;
            rt_ff[j]  <= rt_b;
            yv_ff[j]  <= yv_ff[j-1];
         end
      end
   end

   assign root = rt_ff[SQRT_STAGES];

endmodule

[hdl/bmns_trig.sv]
`timescale 1ns / 1ps
module bmns_trig import bmns_pkg::*; (
   input  logic        clock,
   input  logic        adv,
   input  logic [31:0] uniform_angle,
   output trig_type    trig
);

   typedef struct packed {
      logic [29:0] t;
      logic [29:0] x2;
      logic [1:0]  quad;
      logic        fold;
   } ctx_type;

   typedef enum logic [1:0] {
      QUAD_0 = 2'd0,
      QUAD_1 = 2'd1,
      QUAD_2 = 2'd2,
      QUAD_3 = 2'd3
   } quad_type;

   localparam int LAST = ANG_DEPTH - 2;

   ctx_type     ctx_ff [0:LAST];
   logic [29:0] b_ff;
   logic [30:0] hs_ff [0:TRIG_LEVELS-1];
   logic [30:0] hc_ff [0:TRIG_LEVELS-1];
   logic [29:0] ans_ff [0:TRIG_LEVELS-1];
   logic [29:0] anc_ff [0:TRIG_LEVELS-1];
   logic [29:0] bns_ff [0:TRIG_LEVELS-1];
   logic [29:0] bnc_ff [0:TRIG_LEVELS-1];
   logic [29:0] bqs_ff [0:TRIG_LEVELS-1];
   logic [29:0] bqc_ff [0:TRIG_LEVELS-1];
   trig_type    trig_ff;

   logic [60:0] tp;
   logic [59:0] xp;
   logic [30:0] sp, cp, ps, pc;

   always_ff @(posedge clock) begin
      if (adv) begin
         ctx_ff[0] <= '{t: '0, x2: '0, quad: uniform_angle[31:30], fold: uniform_angle[29]};
         b_ff <= uniform_angle[29] ? 30'(31'(ONE_Q30) - 31'(uniform_angle[29:0]))
                                   : uniform_angle[29:0];
      end
   end

   assign tp = 61'(b_ff) * 61'(HALF_PI_Q30);
   assign xp = 60'(ctx_ff[1].t) * 60'(ctx_ff[1].t);

   always_ff @(posedge clock) begin
      if (adv) begin
         ctx_ff[1] <= '{t: tp[59:30], x2: ctx_ff[0].x2,
                        quad: ctx_ff[0].quad, fold: ctx_ff[0].fold};
         ctx_ff[2] <= '{t: ctx_ff[1].t, x2: xp[59:30],
                        quad: ctx_ff[1].quad, fold: ctx_ff[1].fold};
      end
   end

   for (genvar l = 0; l < TRIG_LEVELS; l++) begin : g_level
      localparam int SA = 3 + 3 * l;
      logic [30:0] hs_prev, hc_prev;
      logic [29:0] mul_s;
      logic [60:0] as_p, ac_p;
      logic [61:0] bs_p, bc_p;
      logic [29:0] qs, qc;

      if (l == 0) begin : g_first
         assign hs_prev = ONE_Q30;
         assign hc_prev = ONE_Q30;
      end else begin : g_next
         assign hs_prev = hs_ff[l-1];
         assign hc_prev = hc_ff[l-1];
      end

      assign mul_s = (l == TRIG_LEVELS - 1) ? ctx_ff[SA-1].t : ctx_ff[SA-1].x2;
      assign as_p  = 61'(mul_s) * 61'(hs_prev);
      assign ac_p  = 61'(ctx_ff[SA-1].x2) * 61'(hc_prev);

      if (l == TRIG_LEVELS - 1) begin : g_sin_last
         assign bs_p = '0;
         assign qs   = '0;
      end else begin : g_sin_div
         assign bs_p = 62'(ans_ff[l]) * 62'(SIN_RECIP[l]);
         assign qs   = div_fix(bns_ff[l], bqs_ff[l], SIN_DIV[l]);
      end
      assign bc_p = 62'(anc_ff[l]) * 62'(COS_RECIP[l]);
      assign qc   = div_fix(bnc_ff[l], bqc_ff[l], COS_DIV[l]);

      always_ff @(posedge clock) begin
         if (adv) begin
            ctx_ff[SA]   <= ctx_ff[SA-1];
            ans_ff[l]    <= as_p[59:30];
            anc_ff[l]    <= ac_p[59:30];
            ctx_ff[SA+1] <= ctx_ff[SA];
            bns_ff[l]    <= ans_ff[l];
            bnc_ff[l]    <= anc_ff[l];
            bqs_ff[l]    <= bs_p[61:32];
            bqc_ff[l]    <= bc_p[61:32];
            ctx_ff[SA+2] <= ctx_ff[SA+1];
            hs_ff[l]     <= (l == TRIG_LEVELS - 1) ? 31'(bns_ff[l]) : ONE_Q30 - 31'(qs);
            hc_ff[l]     <= ONE_Q30 - 31'(qc);
         end
      end
   end

   always_comb begin
      ps = hs_ff[TRIG_LEVELS-1];
      pc = hc_ff[TRIG_LEVELS-1];
      sp = ctx_ff[LAST].fold ? pc : ps;
      cp = ctx_ff[LAST].fold ? ps : pc;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         case (quad_type'(ctx_ff[LAST].quad))
            QUAD_0: begin
               trig_ff <= '{cos_mag: cp, cos_neg: 1'b0, sin_mag: sp, sin_neg: 1'b0};
            end
            QUAD_1: begin
               trig_ff <= '{cos_mag: sp, cos_neg: 1'b1, sin_mag: cp, sin_neg: 1'b0};
            end
            QUAD_2: begin
               trig_ff <= '{cos_mag: cp, cos_neg: 1'b1, sin_mag: sp, sin_neg: 1'b1};
            end
            default: begin
               trig_ff <= '{cos_mag: sp, cos_neg: 1'b0, sin_mag: cp, sin_neg: 1'b1};
            end
         endcase
      end
   end

   assign trig = trig_ff;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
module tb;
   import bmns_pkg::*;

   class pair_scoreboard;
      rsp_type pending[$];
      int unsigned mismatches;
      int unsigned unexpected;
      int unsigned checked;
      logic [31:0] mean_value;
      logic [30:0] std_dev;
      logic [31:0] clip_floor;
      logic        clip_enable;

      function new();
         mean_value  = 32'd0;
         std_dev     = 31'd65536;
         clip_floor  = 32'h8000_0000;
         clip_enable = 1'b0;
      endfunction

      function void write_reg(csr_index_type idx, logic [31:0] value);
         case (idx)
            CSR_MEAN:  mean_value = value;
            CSR_STD:   std_dev = value[30:0];
            CSR_FLOOR: clip_floor = value;
            CSR_CLIP:  clip_enable = value[0];
            default: ;
         endcase
      endfunction

      function logic [63:0] neg_log2(logic [31:0] u);
         int p;
         logic [63:0] x;
         logic [63:0] frac;
         frac = 0;
         if (u == 0) u = 1;
         p = 31;
         while (p > 0 && u[p] == 1'b0) p--;
         x = 64'(u) << (31 - p);
         for (int i = 0; i < 28; i++) begin
            x = (x * x) >> 31;
            frac = frac << 1;
            if (x >= 64'h1_0000_0000) begin
               frac = frac | 64'd1;
               x = x >> 1;
            end
         end
         return (64'(32 - p) << 28) - frac;
      endfunction

      function logic [63:0] root(logic [63:0] v);
         logic [63:0] rem, res, b;
         rem = v;
         res = 0;
         b = 64'd1 << 62;
         while (b > v) b = b >> 2;
         while (b != 0) begin
            if (rem >= res + b) begin
               rem = rem - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
         return res;
      endfunction

      function logic [63:0] stage(logic [63:0] h, logic [63:0] x2, logic [63:0] k);
         return (64'd1 << 30) - ((x2 * h) >> 30) / k;
      endfunction

      function void sincos(logic [31:0] a, output longint cv, output longint sv);
         logic [1:0] q;
         logic [63:0] b, t, x2, hs, hc, sp, cp, tmp;
         logic fold;
         q = a[31:30];
         b = 64'(a[29:0]);
         fold = b >= (64'd1 << 29);
         if (fold) b = (64'd1 << 30) - b;
         t = (b * 64'd1686629713) >> 30;
         x2 = (t * t) >> 30;
         hs = 64'd1 << 30;
         hs = stage(hs, x2, 72);
         hs = stage(hs, x2, 42);
         hs = stage(hs, x2, 20);
         hs = stage(hs, x2, 6);
         sp = (t * hs) >> 30;
         hc = 64'd1 << 30;
         hc = stage(hc, x2, 90);
         hc = stage(hc, x2, 56);
         hc = stage(hc, x2, 30);
         hc = stage(hc, x2, 12);
         cp = stage(hc, x2, 2);
         if (fold) begin
            tmp = sp;
            sp = cp;
            cp = tmp;
         end
         case (q)
            2'd0: begin cv = cp; sv = sp; end
            2'd1: begin cv = -longint'(sp); sv = cp; end
            2'd2: begin cv = -longint'(cp); sv = -longint'(sp); end
            default: begin cv = sp; sv = -longint'(cp); end
         endcase
      endfunction

      function logic [31:0] scale(logic [63:0] r, longint trig);
         longint prod, s;
         logic neg;
         logic [63:0] mag, v;
         prod = longint'(r) * trig;
         neg = prod < 0;
         mag = neg ? -prod : prod;
         v = (64'(std_dev) * (mag >> 30) + (64'd1 << 28)) >> 29;
         s = neg ? -longint'(v) : longint'(v);
         s = s + longint'($signed(mean_value));
         if (s > 64'sd2147483647) s = 64'sd2147483647;
         if (s < -64'sd2147483648) s = -64'sd2147483648;
         if (clip_enable && s < longint'($signed(clip_floor)))
            s = longint'($signed(clip_floor));
         return s[31:0];
      endfunction

      function void note_pair(req_type w);
         logic [63:0] y, r;
         longint cv, sv;
         rsp_type e;
         y = (neg_log2(w.uniform_radius) * 64'd1488522236) >> 30;
         r = root(y << 30);
         sincos(w.uniform_angle, cv, sv);
         e.first_value = scale(r, cv);
         e.second_value = scale(r, sv);
         pending.push_back(e);
      endfunction

      function void check_pair(rsp_type got);
         rsp_type e;
         checked++;
         if (pending.size() == 0) begin
            unexpected++;
            if (mismatches + unexpected <= 10)
               $display("unexpected word %h", got);
            return;
         end
         e = pending.pop_front();
         if (got.first_value !== e.first_value || got.second_value !== e.second_value) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp %h %h got %h %h", e.first_value, e.second_value,
                        got.first_value, got.second_value);
         end
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [1:0] csr_index = 2'd0;
   logic [31:0] csr_data = 32'd0;

   pair_scoreboard board = new();
   int unsigned idle_cycles = 0;
   int unsigned accepted = 0;
   bit calm = 1'b0;
   bit hold_off = 1'b0;
   bit timed_out = 1'b0;

   box_muller_normal_scaler i_dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready) begin
            board.note_pair(req_data);
            accepted++;
         end
         if (rsp_valid && rsp_ready) board.check_pair(rsp_data);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles > 4000) timed_out = 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || hold_off) rsp_ready <= 1'b0;
      else rsp_ready <= calm ? 1'b1 : ($urandom_range(99) >= 23);
   end

   task automatic send_pair(logic [31:0] rad, logic [31:0] ang);
      while (!calm && $urandom_range(99) < 23) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= '{uniform_radius: rad, uniform_angle: ang};
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic write_reg(csr_index_type idx, logic [31:0] value);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      board.write_reg(idx, value);
      @(posedge clock);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (board.pending.size() != 0 && !timed_out) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   task automatic random_pairs(int n);
      logic [31:0] r;
      for (int i = 0; i < n; i++) begin
         case ($urandom_range(3))
            0: r = $urandom_range(255);
            1: r = 32'hFFFF_FFFF - $urandom_range(255);
            default: r = $urandom;
         endcase
         send_pair(r, $urandom);
      end
   endtask

   task automatic run_all();
      logic [31:0] dirs [10];
      dirs = '{32'd0, 32'd1, 32'd2, 32'h8000_0000, 32'hFFFF_FFFF, 32'h4000_0000,
               32'h2000_0000, 32'hC000_0000, 32'h1FFF_FFFF, 32'hE000_0000};
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int i = 0; i < 10; i++) send_pair(dirs[i], dirs[9 - i]);
      send_pair(32'd0, 32'd0);
      send_pair(32'hFFFF_FFFF, 32'hFFFF_FFFF);
      drain();
      write_reg(CSR_MEAN, 32'h7FFF_FFFF);
      write_reg(CSR_STD, 32'h7FFF_FFFF);
      write_reg(CSR_FLOOR, 32'h0001_0000);
      write_reg(CSR_CLIP, 32'hFFFF_FFFF);
      for (int i = 0; i < 10; i++) send_pair(dirs[i], dirs[i]);
      drain();
      write_reg(CSR_MEAN, 32'h8000_0000);
      write_reg(CSR_FLOOR, 32'h8000_0000);
      write_reg(CSR_CLIP, 32'd0);
      random_pairs(60);
      drain();
      write_reg(CSR_STD, 32'd0);
      write_reg(CSR_MEAN, 32'hFFFE_8000);
      random_pairs(20);
      drain();
      write_reg(CSR_MEAN, 32'd0);
      write_reg(CSR_STD, 32'h0001_0000);
      fork
         begin
            hold_off = 1'b1;
            repeat (300) @(posedge clock);
            hold_off = 1'b0;
         end
         random_pairs(150);
      join
      drain();
      calm = 1'b1;
      random_pairs(150);
      calm = 1'b0;
      drain();
      for (int ph = 0; ph < 4; ph++) begin
         write_reg(CSR_MEAN, $urandom);
         write_reg(CSR_STD, $urandom_range(32'h0008_0000));
         write_reg(CSR_FLOOR, $urandom);
         write_reg(CSR_CLIP, $urandom);
         random_pairs(125);
         drain();
      end
   endtask

   initial begin
      fork
         run_all();
         wait (timed_out);
      join_any
      if (timed_out) begin
         $display("tb: failure");
         $finish;
      end else begin
         $display("covered %0d pairs: edge uniforms, all quadrants, saturation, clipping,",
                  accepted);
         $display("zero and full scale, and a long output stall; %0d words checked",
                  board.checked);
         if (board.mismatches == 0 && board.unexpected == 0 && board.pending.size() == 0)
            $display("tb: success");
         else
            $display("tb: failure");
         $finish;
      end
   end
endmodule
